[sv/id3u8_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and UTF-8 helpers for the ID3 text transcoder.
// No dependencies.
package id3u8_pkg;

   localparam int QUEUE_DEPTH = 4;

   // encoding selector codes carried by the first payload byte
   localparam logic [7:0] ENC_LATIN1    = 8'd0;
   localparam logic [7:0] ENC_UTF16_BOM = 8'd1;
   localparam logic [7:0] ENC_UTF16BE   = 8'd2;
   localparam logic [7:0] ENC_UTF8      = 8'd3;

   localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
   localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE     = 21'h10000;
   localparam logic [7:0]  BOM_FIRST_BE  = 8'hFE;
   localparam logic [7:0]  BOM_SECOND_BE = 8'hFF;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_LATIN1,
      MODE_UTF8,
      MODE_MARK,
      MODE_UTF16,
      MODE_HALT
   } mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       payload_start;
   } req_type;

   typedef struct packed {
      logic [7:0] utf8_byte;
      logic       run_last;
   } rsp_type;

   // one code point waiting for serialization; last_idx is byte count - 1
   typedef struct packed {
      logic [1:0]  last_idx;
      logic [20:0] cp;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic logic [1:0] utf8_last(input logic [20:0] cp);
      logic [1:0] r;
      if (cp < 21'h80)         r = 2'd0;
      else if (cp < 21'h800)   r = 2'd1;
      else if (cp < 21'h10000) r = 2'd2;
      else                     r = 2'd3;
      return r;
   endfunction

   // byte idx of the UTF-8 form; a one-byte form passes cp[7:0] untouched
   function automatic logic [7:0] utf8_pick(input logic [20:0] cp,
                                            input logic [1:0] last_idx,
                                            input logic [1:0] idx);
      logic [7:0] r;
      r = cp[7:0];
      unique case (last_idx)
         2'd0: r = cp[7:0];
         2'd1: begin
            if (idx == 2'd0) r = {3'b110, cp[10:6]};
            else             r = {2'b10, cp[5:0]};
         end
         2'd2: begin
            if (idx == 2'd0)      r = {4'b1110, cp[15:12]};
            else if (idx == 2'd1) r = {2'b10, cp[11:6]};
            else                  r = {2'b10, cp[5:0]};
         end
         default: begin
            if (idx == 2'd0)      r = {5'b11110, cp[20:18]};
            else if (idx == 2'd1) r = {2'b10, cp[17:12]};
            else if (idx == 2'd2) r = {2'b10, cp[11:6]};
            else                  r = {2'b10, cp[5:0]};
         end
      endcase
      return r;
   endfunction

endpackage

[sv/id3u8_front.sv]
`timescale 1ns / 1ps
// Front end: tracks the encoding and UTF-16 state, turns each accepted item
// into at most one code point for the queue. Uses id3u8_pkg.
module id3u8_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_accept,
   input  id3u8_pkg::req_type in_data,
   output id3u8_pkg::push_type push_out
);
   import id3u8_pkg::*;

   mode_type    mode_ff, mode_in;
   logic        be_ff, be_in;
   logic        phase_ff, phase_in;
   logic [7:0]  held_ff, held_in;
   logic        hp_ff, hp_in;
   logic [9:0]  hb_ff, hb_in;

   logic [7:0]  b;
   logic [15:0] unit;
   logic        is_high, is_low;
   logic [20:0] pair_cp;

   assign b       = in_data.data_byte;
   assign unit    = be_ff ? {held_ff, b} : {b, held_ff};
   assign is_high = (unit >= HIGH_SURR_MIN) && (unit <= HIGH_SURR_MAX);
   assign is_low  = (unit >= LOW_SURR_MIN) && (unit <= LOW_SURR_MAX);
   assign pair_cp = SUPP_BASE + {1'b0, hb_ff, unit[9:0]};

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (in_accept) begin
         if (in_data.payload_start) begin
            unique case (b)
               ENC_LATIN1:    mode_in = MODE_LATIN1;
               ENC_UTF16_BOM: mode_in = MODE_MARK;
               ENC_UTF16BE:   mode_in = MODE_UTF16;
               ENC_UTF8:      mode_in = MODE_UTF8;
               default:       mode_in = MODE_HALT;
            endcase
         end else begin
            unique case (mode_ff)
               MODE_MARK:  if (phase_ff) mode_in = MODE_UTF16;
               MODE_UTF16: if (phase_ff && unit == 16'h0) mode_in = MODE_HALT;
               default:    mode_in = mode_ff;
            endcase
         end
      end
   end

   // datapath state and queue push
   always_comb begin
      be_in    = be_ff;
      phase_in = phase_ff;
      held_in  = held_ff;
      hp_in    = hp_ff;
      hb_in    = hb_ff;
      push_out = '0;
      if (in_accept) begin
         if (in_data.payload_start) begin
            be_in    = (b == ENC_UTF16BE);
            phase_in = 1'b0;
            held_in  = 8'h0;
            hp_in    = 1'b0;
            hb_in    = 10'h0;
         end else begin
            unique case (mode_ff)
               MODE_LATIN1: begin
                  push_out.push           = 1'b1;
                  push_out.entry.cp       = {13'h0, b};
                  push_out.entry.last_idx = utf8_last({13'h0, b});
               end
               MODE_UTF8: begin
                  push_out.push           = 1'b1;
                  push_out.entry.cp       = {13'h0, b};
                  push_out.entry.last_idx = 2'd0;
               end
               MODE_MARK: begin
                  if (!phase_ff) begin
                     held_in  = b;
                     phase_in = 1'b1;
                  end else begin
                     be_in    = (held_ff == BOM_FIRST_BE) && (b == BOM_SECOND_BE);
                     phase_in = 1'b0;
                  end
               end
               MODE_UTF16: begin
                  if (!phase_ff) begin
                     held_in  = b;
                     phase_in = 1'b1;
                  end else begin
                     phase_in = 1'b0;
                     hp_in    = 1'b0;
                     if (unit == 16'h0) begin
                        hp_in = 1'b0;
                     end else if (hp_ff && is_low) begin
                        push_out.push           = 1'b1;
                        push_out.entry.cp       = pair_cp;
                        push_out.entry.last_idx = 2'd3;
                     end else if (is_high) begin
                        hp_in = 1'b1;
                        hb_in = unit[9:0];
                     end else if (!is_low) begin
                        push_out.push           = 1'b1;
                        push_out.entry.cp       = {5'h0, unit};
                        push_out.entry.last_idx = utf8_last({5'h0, unit});
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         be_ff    <= 1'b0;
         phase_ff <= 1'b0;
         held_ff  <= 8'h0;
         hp_ff    <= 1'b0;
         hb_ff    <= 10'h0;
      end else begin
         mode_ff  <= mode_in;
         be_ff    <= be_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
         hp_ff    <= hp_in;
         hb_ff    <= hb_in;
      end
   end

endmodule

[sv/id3u8_queue.sv]
`timescale 1ns / 1ps
// Short code point queue between front and back end.
// Uses id3u8_pkg.
module id3u8_queue #(
   parameter int DEPTH = id3u8_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  id3u8_pkg::push_type  push_in,
   input  logic                 pop,
   output id3u8_pkg::entry_type head,
   output id3u8_pkg::q_stat_type stat
);
   import id3u8_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   entry_type         mem_ff [DEPTH];
   logic [PW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign do_push    = push_in.push && (cnt_ff != CNT_FULL);
   assign do_pop     = pop && (cnt_ff != '0);
   assign head       = mem_ff[rd_ff];
   assign stat.full  = (cnt_ff == CNT_FULL);
   assign stat.empty = (cnt_ff == '0);

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop)      cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_in.entry;
   end

endmodule

[sv/id3u8_back.sv]
`timescale 1ns / 1ps
// Back end: serializes the head code point into UTF-8 bytes, one per cycle
// while rsp_stall is low, into the output register. Uses id3u8_pkg.
module id3u8_back (
   input  logic                  clock,
   input  logic                  reset,
   input  id3u8_pkg::entry_type  head,
   input  id3u8_pkg::q_stat_type stat,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output id3u8_pkg::rsp_type    rsp_data
);
   import id3u8_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    data_ff, data_in;
   logic       load, at_last;

   // output register may refill while its current byte is taken
   assign load    = !stat.empty && (!valid_ff || !rsp_stall);
   assign at_last = (idx_ff == head.last_idx);
   assign pop     = load && at_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in          = 1'b1;
         data_in.utf8_byte = utf8_pick(head.cp, head.last_idx, idx_ff);
         data_in.run_last  = at_last;
         idx_in            = at_last ? 2'd0 : idx_ff + 2'd1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[sv/id3_text_to_utf8_transcoder.sv]
`timescale 1ns / 1ps
// ID3 text payload to UTF-8 transcoder, top level.
// Instantiates id3u8_front, id3u8_queue and id3u8_back; uses id3u8_pkg.
//
// Input channel (req_*): one payload byte per item; payload_start marks the
// encoding byte (0 Latin-1, 1 UTF-16 with mark, 2 UTF-16BE, 3 UTF-8).
// Result channel (rsp_*): one UTF-8 byte per item, run_last set on the last
// byte produced by a given input byte. Input bytes that produce nothing
// (encoding bytes, marks, first half of a UTF-16 unit, surrogates waiting
// for a partner) give no result.
// Throughput: the front end takes one item per cycle while the queue has
// room; the back end emits one byte per cycle while rsp_stall is low, so
// an input byte that maps to N UTF-8 bytes (1 to 4) occupies the output
// until all N are taken. An accepted item is written into a queue entry,
// and its first byte is then loaded into the output register.
// req_stall is high while the code point queue (QUEUE_DEPTH entries) is
// full. When rsp_stall is held the output byte holds and the queue fills,
// after which req_stall rises.
// Reset (synchronous) returns to the idle mode awaiting an encoding byte
// and empties the queue and output register.
module id3_text_to_utf8_transcoder #(
   parameter int QUEUE_DEPTH = id3u8_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  id3u8_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output id3u8_pkg::rsp_type rsp_data
);
   import id3u8_pkg::*;

   push_type   push;
   entry_type  head;
   q_stat_type stat;
   logic       pop;
   logic       accept;

   assign req_stall = stat.full;
   assign accept    = req_valid && !req_stall;

   id3u8_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_data   (req_data),
      .push_out  (push)
   );

   id3u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .head    (head),
      .stat    (stat)
   );

   id3u8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .stat      (stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/id3u8_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the transcoder top level, attached by bind.
// Uses id3u8_pkg.
module id3u8_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input id3u8_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input id3u8_pkg::rsp_type rsp_data
);
   import id3u8_pkg::*;

   // a held result keeps its byte
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_in: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled right after reset");

   // bytes of one code point leave back to back
   a_multi_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.run_last |=> rsp_valid)
      else $error("gap inside a multi-byte sequence");

endmodule

bind id3_text_to_utf8_transcoder id3u8_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench for id3_text_to_utf8_transcoder: directed and random tag text items.
// A local transcoder model predicts the UTF-8 bytes; depends on id3u8_pkg.
module tb;
   import id3u8_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int req_gap_pct = 7;
   int rsp_hold_pct = 7;
   int errors = 0;
   int sent_items = 0;

   // model state
   mode_type   dec_mode = MODE_IDLE;
   logic       big_end = 1'b0;
   logic       phase = 1'b0;
   logic [7:0] held = '0;
   logic       hi_pend = 1'b0;
   logic [9:0] hi_bits = '0;

   rsp_type utf8_expected[$];

   id3_text_to_utf8_transcoder dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function void queue_result(input logic [7:0] v, input logic last);
      rsp_type r;
      r.utf8_byte = v;
      r.run_last = last;
      utf8_expected = {utf8_expected, r};
   endfunction

   function void emit_code(input logic [20:0] cp);
      logic [7:0] enc [0:3];
      int n;
      if (cp < 21'h80) begin
         enc[0] = cp[7:0];
         n = 1;
      end else if (cp < 21'h800) begin
         enc[0] = {3'b110, cp[10:6]};
         enc[1] = {2'b10, cp[5:0]};
         n = 2;
      end else if (cp < SUPP_BASE) begin
         enc[0] = {4'b1110, cp[15:12]};
         enc[1] = {2'b10, cp[11:6]};
         enc[2] = {2'b10, cp[5:0]};
         n = 3;
      end else begin
         enc[0] = {5'b11110, cp[20:18]};
         enc[1] = {2'b10, cp[17:12]};
         enc[2] = {2'b10, cp[11:6]};
         enc[3] = {2'b10, cp[5:0]};
         n = 4;
      end
      for (int i = 0; i < n; i++) queue_result(enc[i], i == n - 1);
   endfunction

   function void decode_unit(input logic [15:0] u);
      if (u == 16'd0) begin
         hi_pend = 1'b0;
         dec_mode = MODE_HALT;
         return;
      end
      if (hi_pend) begin
         hi_pend = 1'b0;
         if (u >= LOW_SURR_MIN && u <= LOW_SURR_MAX) begin
            emit_code(SUPP_BASE + {1'b0, hi_bits, u[9:0]});
            return;
         end
      end
      if (u >= HIGH_SURR_MIN && u <= HIGH_SURR_MAX) begin
         hi_pend = 1'b1;
         hi_bits = u[9:0];
      end else if (!(u >= LOW_SURR_MIN && u <= LOW_SURR_MAX)) begin
         emit_code({5'd0, u});
      end
   endfunction

   // advance the model by one accepted item
   function void transcode_byte(input req_type it);
      logic [7:0] b;
      b = it.data_byte;
      sent_items++;
      if (it.payload_start) begin
         phase = 1'b0;
         held = '0;
         hi_pend = 1'b0;
         hi_bits = '0;
         big_end = 1'b0;
         case (b)
            ENC_LATIN1:    dec_mode = MODE_LATIN1;
            ENC_UTF16_BOM: dec_mode = MODE_MARK;
            ENC_UTF16BE: begin
               dec_mode = MODE_UTF16;
               big_end = 1'b1;
            end
            ENC_UTF8:      dec_mode = MODE_UTF8;
            default:       dec_mode = MODE_HALT;
         endcase
         return;
      end
      case (dec_mode)
         MODE_LATIN1: emit_code({13'd0, b});
         MODE_UTF8:   queue_result(b, 1'b1);
         MODE_MARK: begin
            if (!phase) begin
               held = b;
               phase = 1'b1;
            end else begin
               big_end = (held == BOM_FIRST_BE && b == BOM_SECOND_BE);
               phase = 1'b0;
               dec_mode = MODE_UTF16;
            end
         end
         MODE_UTF16: begin
            if (!phase) begin
               held = b;
               phase = 1'b1;
            end else begin
               phase = 1'b0;
               decode_unit(big_end ? {held, b} : {b, held});
            end
         end
         default: ;
      endcase
   endfunction

   task send_byte(input logic [7:0] b, input logic start);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{b, start};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      transcode_byte('{b, start});
   endtask

   task send_unit(input logic [15:0] u, input logic be);
      if (be) begin
         send_byte(u[15:8], 1'b0);
         send_byte(u[7:0], 1'b0);
      end else begin
         send_byte(u[7:0], 1'b0);
         send_byte(u[15:8], 1'b0);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (utf8_expected.size() == 0) begin
            $display("%0t: unexpected item: expected none, actual byte %h last %b",
                     $time, rsp_data.utf8_byte, rsp_data.run_last);
            errors++;
         end else begin
            want = utf8_expected.pop_front();
            if (rsp_data.utf8_byte !== want.utf8_byte) begin
               $display("%0t: utf8_byte mismatch: expected %h, actual %h",
                        $time, want.utf8_byte, rsp_data.utf8_byte);
               errors++;
            end
            if (rsp_data.run_last !== want.run_last) begin
               $display("%0t: run_last mismatch: expected %b, actual %b",
                        $time, want.run_last, rsp_data.run_last);
               errors++;
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < rsp_hold_pct);
   end

   // watchdog: ends the run after a long stretch with no item moving
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   task test_bytes_before_payload();
      send_byte(8'h55, 1'b0);
   endtask

   task test_latin1();
      send_byte(ENC_LATIN1, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
   endtask

   task test_utf8_passthrough();
      send_byte(ENC_UTF8, 1'b1);
      send_byte(8'hFF, 1'b0);
   endtask

   task test_utf16_mark();
      // big-endian mark, then the highest surrogate pair
      send_byte(ENC_UTF16_BOM, 1'b1);
      send_byte(BOM_FIRST_BE, 1'b0);
      send_byte(BOM_SECOND_BE, 1'b0);
      send_unit(16'hDBFF, 1'b1);
      send_unit(16'hDFFF, 1'b1);
      // reversed mark, one unit, then a dangling odd byte
      send_byte(ENC_UTF16_BOM, 1'b1);
      send_byte(BOM_SECOND_BE, 1'b0);
      send_byte(BOM_FIRST_BE, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_byte(8'h12, 1'b0);
   endtask

   task test_utf16be();
      // lone high and low surrogates, U+FFFF, then a zero unit halts the payload
      send_byte(ENC_UTF16BE, 1'b1);
      send_unit(HIGH_SURR_MIN, 1'b1);
      send_unit(16'h0041, 1'b1);
      send_unit(LOW_SURR_MIN, 1'b1);
      send_unit(16'hFFFF, 1'b1);
      send_unit(HIGH_SURR_MIN, 1'b1);
      send_unit(16'h0000, 1'b1);
      send_byte(8'h41, 1'b0);
   endtask

   task test_unknown_encoding();
      send_byte(8'hFF, 1'b1);
      send_byte(8'h41, 1'b0);
   endtask

   task send_random_units(input logic be, input int units);
      logic [15:0] u;
      logic [19:0] off;
      int kind;
      for (int i = 0; i < units; i++) begin
         kind = $urandom_range(0, 19);
         off = 20'($urandom);
         if (kind < 6) begin
            send_unit(16'($urandom_range(1, 16'hFFFF)), be);
         end else if (kind < 9) begin
            send_unit(16'($urandom_range(1, 16'h7F)), be);
         end else if (kind < 11) begin
            send_unit(16'($urandom_range(16'h80, 16'h7FF)), be);
         end else if (kind < 15) begin
            send_unit(HIGH_SURR_MIN | {6'd0, off[19:10]}, be);
            send_unit(LOW_SURR_MIN | {6'd0, off[9:0]}, be);
         end else if (kind < 17) begin
            send_unit(HIGH_SURR_MIN | {6'd0, off[9:0]}, be);
         end else if (kind < 19) begin
            send_unit(LOW_SURR_MIN | {6'd0, off[9:0]}, be);
         end else begin
            u = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
            send_unit(u, be);
         end
      end
   endtask

   task send_random_payload();
      int pick;
      int len;
      int m;
      logic be;
      pick = $urandom_range(0, 19);
      len = $urandom_range(0, 12);
      if (pick < 5 || (pick >= 5 && pick < 8)) begin
         send_byte((pick < 5) ? ENC_LATIN1 : ENC_UTF8, 1'b1);
         for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 13) begin
         send_byte(ENC_UTF16_BOM, 1'b1);
         m = $urandom_range(0, 3);
         if (m < 2) begin
            send_byte(BOM_FIRST_BE, 1'b0);
            send_byte(BOM_SECOND_BE, 1'b0);
            be = 1'b1;
         end else if (m == 2) begin
            send_byte(BOM_SECOND_BE, 1'b0);
            send_byte(BOM_FIRST_BE, 1'b0);
            be = 1'b0;
         end else begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            be = 1'b0;
         end
         send_random_units(be, len);
      end else if (pick < 18) begin
         send_byte(ENC_UTF16BE, 1'b1);
         send_random_units(1'b1, len);
      end else begin
         send_byte(8'($urandom_range(4, 255)), 1'b1);
         for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      // occasional broken tail: an odd trailing byte
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task test_random_text(input int goal);
      while (sent_items < goal) send_random_payload();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bytes_before_payload();
      test_latin1();
      test_utf8_passthrough();
      test_utf16_mark();
      test_utf16be();
      test_unknown_encoding();
      req_gap_pct = 0;
      rsp_hold_pct = 0;
      test_random_text(160);
      req_gap_pct = 7;
      rsp_hold_pct = 7;
      test_random_text(370);
      req_valid <= 1'b0;
      while (utf8_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
